// File: src/bdlp_pkg.sv
// bdlp_pkg: shared types, register indexes and reset values for the
// button debounce and long-press block; no dependencies
`default_nettype none
package bdlp_pkg;

  localparam int unsigned CounterBitsDefault = 16;
  localparam int unsigned RegW               = 16;
  localparam int unsigned CfgIdxW            = 2;
  localparam int unsigned InDataW            = 8;
  localparam int unsigned OutDataW           = 8;
  localparam int unsigned ReqW               = 2;

  localparam logic [CfgIdxW-1:0] RegDebounce     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCommission   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFactoryReset = 2'd2;

  localparam logic [RegW-1:0] DebounceReset     = 16'd1;
  localparam logic [RegW-1:0] CommissionReset   = 16'd140;
  localparam logic [RegW-1:0] FactoryResetReset = 16'd300;

  typedef enum logic [ReqW-1:0] {
    ReqNone         = 2'd0,
    ReqCommission   = 2'd1,
    ReqFactoryReset = 2'd2
  } req_e;

  typedef struct packed {
    logic [RegW-1:0] debounce_polls;
    logic [RegW-1:0] commission_hold_polls;
    logic [RegW-1:0] factory_reset_hold_polls;
  } cfg_t;

  typedef struct packed {
    req_e release_request;
    logic preview_factory_reset;
    logic preview_commission;
    logic state_changed;
    logic debounced_pressed;
  } result_t;

endpackage
`default_nettype wire

// File: src/bdlp_cfg.sv
// bdlp_cfg: threshold register file written through the plain write port
// depends on bdlp_pkg
`default_nettype none
module bdlp_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bdlp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bdlp_pkg::RegW-1:0]     cfg_wdata_i,
  output bdlp_pkg::cfg_t                     cfg_o
);

  bdlp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdlp_pkg::RegDebounce:     cfg_d.debounce_polls           = cfg_wdata_i;
        bdlp_pkg::RegCommission:   cfg_d.commission_hold_polls    = cfg_wdata_i;
        bdlp_pkg::RegFactoryReset: cfg_d.factory_reset_hold_polls = cfg_wdata_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_polls           <= bdlp_pkg::DebounceReset;
      cfg_q.commission_hold_polls    <= bdlp_pkg::CommissionReset;
      cfg_q.factory_reset_hold_polls <= bdlp_pkg::FactoryResetReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: src/bdlp_step.sv
// bdlp_step: debounce and hold-time state with the per-poll update logic
// depends on bdlp_pkg
`default_nettype none
module bdlp_step #(
  parameter int unsigned COUNTER_BITS = bdlp_pkg::CounterBitsDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic           raw_i,
  input  wire bdlp_pkg::cfg_t cfg_i,
  output bdlp_pkg::result_t   result_o
);

  localparam int unsigned CmpW = (COUNTER_BITS > bdlp_pkg::RegW) ? COUNTER_BITS
                                                                 : bdlp_pkg::RegW;

  logic                    last_raw_q, last_raw_d;
  logic                    reported_q, reported_d;
  logic [COUNTER_BITS-1:0] age_q, age_d;
  logic [COUNTER_BITS-1:0] hold_q, hold_d;
  logic                    cdone_q, cdone_d;
  logic                    rdone_q, rdone_d;
  logic                    cflag_q, cflag_d;
  logic                    rflag_q, rflag_d;

  logic                    same;
  logic                    accept;
  logic [COUNTER_BITS-1:0] hold_inc;
  logic [CmpW-1:0]         hold_x, age_x, deb_x, com_x, fr_x, hinc_x;
  bdlp_pkg::req_e          req;

  always_comb begin
    hold_inc = reported_q ? ((&hold_q) ? hold_q : hold_q + 1'b1) : hold_q;
    same     = (raw_i == last_raw_q);
    age_d    = same ? ((&age_q) ? age_q : age_q + 1'b1) : '0;
    age_x    = CmpW'(age_d);
    deb_x    = CmpW'(cfg_i.debounce_polls);
    com_x    = CmpW'(cfg_i.commission_hold_polls);
    fr_x     = CmpW'(cfg_i.factory_reset_hold_polls);
    hinc_x   = CmpW'(hold_inc);
    accept   = same && (raw_i != reported_q) && (age_x >= deb_x);

    last_raw_d = raw_i;
    reported_d = accept ? raw_i : reported_q;
    hold_d     = hold_inc;
    cdone_d    = cdone_q;
    rdone_d    = rdone_q;
    cflag_d    = cflag_q;
    rflag_d    = rflag_q;
    req        = bdlp_pkg::ReqNone;

    if (accept && raw_i) begin
      hold_d  = '0;
      cdone_d = 1'b0;
      rdone_d = 1'b0;
    end
    if (accept && !raw_i) begin
      cflag_d = 1'b0;
      rflag_d = 1'b0;
      if (hinc_x >= fr_x) begin
        req = bdlp_pkg::ReqFactoryReset;
      end else if (hinc_x >= com_x) begin
        req = bdlp_pkg::ReqCommission;
      end
    end

    hold_x = CmpW'(hold_d);
    if (reported_d) begin
      if ((hold_x >= fr_x) && !rdone_d) begin
        rdone_d = 1'b1;
        cflag_d = 1'b0;
        rflag_d = 1'b1;
      end else if ((hold_x >= com_x) && !cdone_d) begin
        cdone_d = 1'b1;
        cflag_d = 1'b1;
      end
    end

    result_o.debounced_pressed     = reported_d;
    result_o.state_changed         = accept;
    result_o.preview_commission    = cflag_d;
    result_o.preview_factory_reset = rflag_d;
    result_o.release_request       = req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      reported_q <= 1'b0;
      age_q      <= '0;
      hold_q     <= '0;
      cdone_q    <= 1'b0;
      rdone_q    <= 1'b0;
      cflag_q    <= 1'b0;
      rflag_q    <= 1'b0;
    end else if (step_i) begin
      last_raw_q <= last_raw_d;
      reported_q <= reported_d;
      age_q      <= age_d;
      hold_q     <= hold_d;
      cdone_q    <= cdone_d;
      rdone_q    <= rdone_d;
      cflag_q    <= cflag_d;
      rflag_q    <= rflag_d;
    end
  end

endmodule
`default_nettype wire

// File: src/button_debounce_long_press.sv
// button_debounce_long_press: top level, input register, output register
// depends on bdlp_pkg, bdlp_cfg, bdlp_step
//
//   channel  dir  handshake                tdata fields (lsb up)
//   s_axis   in   s_axis_tvalid/tready     raw_pressed
//   m_axis   out  m_axis_tvalid/tready     debounced_pressed, state_changed,
//                                          preview_commission,
//                                          preview_factory_reset, release_request
//   cfg      in   cfg_we_i                 0 debounce, 1 commission, 2 factory reset
//
// one request per cycle sustained while the output is not stalled; a request accepted
// into the input register moves into the result register once the output can advance
// each request passes the input register, then the update logic into the result register
// reset: button released, counters zero, thresholds 1/140/300
// a stalled output holds the pipeline; the input register still takes a request
// whenever it is empty
`default_nettype none
module button_debounce_long_press #(
  parameter int unsigned COUNTER_BITS = bdlp_pkg::CounterBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [bdlp_pkg::InDataW-1:0]   s_axis_tdata,   // raw_pressed
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // debounced_pressed, state_changed, preview_commission,
  // preview_factory_reset, release_request[1:0]
  output logic [bdlp_pkg::OutDataW-1:0]       m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [bdlp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bdlp_pkg::RegW-1:0]      cfg_wdata_i
);

  bdlp_pkg::cfg_t    cfg;
  bdlp_pkg::result_t result;

  logic              in_valid_q;
  logic              in_raw_q;
  logic              out_valid_q;
  bdlp_pkg::result_t out_q;
  logic              advance;
  logic              step;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  bdlp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdlp_step #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .raw_i    (in_raw_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_raw_q <= s_axis_tdata[0];
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = bdlp_pkg::OutDataW'(out_q);

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for button_debounce_long_press, drives button polls on
// the input stream, predicts every debounced report and checks it on the output stream
// depends on bdlp_pkg and button_debounce_long_press
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CntW = bdlp_pkg::CounterBitsDefault;
  localparam int unsigned ResW = $bits(bdlp_pkg::result_t);
  localparam logic [bdlp_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  class button_tracker;
    bdlp_pkg::cfg_t    regs;
    logic              last_raw;
    logic              reported;
    logic [CntW-1:0]   stable_age;
    logic [CntW-1:0]   hold_count;
    logic              comm_done;
    logic              reset_done;
    logic              comm_flag;
    logic              reset_flag;
    bdlp_pkg::result_t pending_reports[$];
    int unsigned       errors;

    function new();
      regs.debounce_polls           = bdlp_pkg::DebounceReset;
      regs.commission_hold_polls    = bdlp_pkg::CommissionReset;
      regs.factory_reset_hold_polls = bdlp_pkg::FactoryResetReset;
      last_raw   = 1'b0;
      reported   = 1'b0;
      stable_age = '0;
      hold_count = '0;
      comm_done  = 1'b0;
      reset_done = 1'b0;
      comm_flag  = 1'b0;
      reset_flag = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [bdlp_pkg::CfgIdxW-1:0] idx, logic [bdlp_pkg::RegW-1:0] value);
      case (idx)
        bdlp_pkg::RegDebounce:     regs.debounce_polls = value;
        bdlp_pkg::RegCommission:   regs.commission_hold_polls = value;
        bdlp_pkg::RegFactoryReset: regs.factory_reset_hold_polls = value;
        default: ;
      endcase
    endfunction

    function logic [CntW-1:0] bump(logic [CntW-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function void poll(logic raw);
      bdlp_pkg::result_t r;
      logic              changed;
      bdlp_pkg::req_e    req;
      changed = 1'b0;
      req     = bdlp_pkg::ReqNone;
      if (reported) hold_count = bump(hold_count);
      if (raw != last_raw) begin
        last_raw   = raw;
        stable_age = '0;
      end else begin
        stable_age = bump(stable_age);
        if (raw != reported && stable_age >= regs.debounce_polls) begin
          reported = raw;
          changed  = 1'b1;
          if (reported) begin
            hold_count = '0;
            comm_done  = 1'b0;
            reset_done = 1'b0;
          end else begin
            comm_flag  = 1'b0;
            reset_flag = 1'b0;
            if (hold_count >= regs.factory_reset_hold_polls) begin
              req = bdlp_pkg::ReqFactoryReset;
            end else if (hold_count >= regs.commission_hold_polls) begin
              req = bdlp_pkg::ReqCommission;
            end
          end
        end
      end
      if (reported) begin
        if (hold_count >= regs.factory_reset_hold_polls && !reset_done) begin
          reset_done = 1'b1;
          comm_flag  = 1'b0;
          reset_flag = 1'b1;
        end else if (hold_count >= regs.commission_hold_polls && !comm_done) begin
          comm_done = 1'b1;
          comm_flag = 1'b1;
        end
      end
      r.debounced_pressed     = reported;
      r.state_changed         = changed;
      r.preview_commission    = comm_flag;
      r.preview_factory_reset = reset_flag;
      r.release_request       = req;
      pending_reports.push_back(r);
    endfunction

    function void check_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic [bdlp_pkg::OutDataW-1:0] data);
      bdlp_pkg::result_t want;
      bdlp_pkg::result_t got;
      got = bdlp_pkg::result_t'(data[ResW-1:0]);
      if (pending_reports.size() == 0) begin
        $error("report with no poll outstanding: tdata %h", data);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      check_field("debounced_pressed", want.debounced_pressed, got.debounced_pressed);
      check_field("state_changed", want.state_changed, got.state_changed);
      check_field("preview_commission", want.preview_commission, got.preview_commission);
      check_field("preview_factory_reset", want.preview_factory_reset,
                  got.preview_factory_reset);
      check_field("release_request", want.release_request, got.release_request);
      check_field("tdata padding", 2'b00, data[bdlp_pkg::OutDataW-1:ResW]);
    endfunction
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [bdlp_pkg::InDataW-1:0]  s_axis_tdata  = '0;   // raw_pressed
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // debounced_pressed, state_changed, preview_commission,
  // preview_factory_reset, release_request[1:0]
  logic [bdlp_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_we_i      = 1'b0;
  logic [bdlp_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [bdlp_pkg::RegW-1:0]     cfg_wdata_i   = '0;

  button_tracker tracker;
  int unsigned   sender_idle_pct = 0;
  int unsigned   recv_stall_pct  = 0;
  int unsigned   polls_sent      = 0;
  int unsigned   idle_by_phase[4]  = '{0, 79, 0, 20};
  int unsigned   stall_by_phase[4] = '{0, 0, 79, 20};

  button_debounce_long_press uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) tracker.poll(s_axis_tdata[0]);
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_report(m_axis_tdata);
  end

  task automatic send_poll(logic raw);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(bdlp_pkg::InDataW-1){1'b0}}, raw};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    polls_sent++;
  endtask

  task automatic send_run(logic raw, int unsigned len);
    repeat (len) send_poll(raw);
  endtask

  task automatic bounce();
    repeat ($urandom_range(0, 3)) send_poll(1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bdlp_pkg::CfgIdxW-1:0] idx, logic [bdlp_pkg::RegW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic load_thresholds(int unsigned deb, int unsigned comm, int unsigned fact);
    drain();
    write_reg(bdlp_pkg::RegDebounce, bdlp_pkg::RegW'(deb));
    write_reg(bdlp_pkg::RegCommission, bdlp_pkg::RegW'(comm));
    write_reg(bdlp_pkg::RegFactoryReset, bdlp_pkg::RegW'(fact));
  endtask

  // bounce, hold around the thresholds, bounce, settle released
  task automatic press_and_release();
    int unsigned deb;
    int unsigned top;
    deb = (tracker.regs.debounce_polls > 6) ? 6 : tracker.regs.debounce_polls;
    top = (tracker.regs.commission_hold_polls > tracker.regs.factory_reset_hold_polls) ?
          tracker.regs.commission_hold_polls : tracker.regs.factory_reset_hold_polls;
    if (top > 90) top = 90;
    bounce();
    send_run(1'b1, deb + 1 + $urandom_range(0, top + 6));
    bounce();
    send_run(1'b0, deb + 1 + $urandom_range(0, 4));
  endtask

  task automatic random_polls(int unsigned n);
    int unsigned stop_at;
    stop_at = polls_sent + n;
    while (polls_sent < stop_at) begin
      if ($urandom_range(9) < 2) begin
        repeat ($urandom_range(1, 8)) send_poll(1'($urandom_range(0, 1)));
      end else begin
        press_and_release();
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero debounce, zero commission hold, short factory hold
    load_thresholds(0, 0, 3);
    send_run(1'b1, 6);
    send_run(1'b0, 2);
    send_poll(1'b1);
    send_poll(1'b0);
    send_run(1'b0, 2);
    send_run(1'b1, 2);
    send_run(1'b0, 2);

    // factory hold below commission hold, unmapped index ignored
    drain();
    write_reg(RegUnused, 16'hFFFF);
    load_thresholds(2, 5, 2);
    send_run(1'b1, 8);
    send_run(1'b0, 3);

    for (int m = 0; m < 4; m++) begin
      drain();
      sender_idle_pct = idle_by_phase[m];
      recv_stall_pct  = stall_by_phase[m];
      load_thresholds($urandom_range(0, 4), $urandom_range(0, 40), $urandom_range(0, 60));
      random_polls(100);
      case (m)
        0: load_thresholds(0, 0, 0);
        1: load_thresholds(16'hFFFF, $urandom_range(0, 40), $urandom_range(0, 60));
        2: load_thresholds($urandom_range(0, 4), 16'hFFFF, 16'hFFFF);
        default: load_thresholds(1, 16'hFFFF, 0);
      endcase
      random_polls(100);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: button_debounce_long_press.f
src/bdlp_pkg.sv
src/bdlp_cfg.sv
src/bdlp_step.sv
src/button_debounce_long_press.sv
bench/tb_top.sv
